// ----- hdl/btff_pkg.sv -----
// Shared types and constants for the block table first-fit allocator.
package btff_pkg;

  // Width of addresses, byte counts and configuration data.
  localparam int unsigned DATA_W = 32;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_ALLOCATE = 2'd0;
  localparam logic [1:0] OP_FREE     = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // Status codes carried by a result item.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BASE_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_BLOCKS_IN_USE = 2'd1;

  // Reset value of the blocks_in_use register.
  localparam logic [10:0] BLOCKS_IN_USE_RESET = 11'd1024;

  // Block table entry bits.
  localparam logic [1:0] ENTRY_FREE     = 2'b00;
  localparam logic [1:0] ENTRY_TAKEN    = 2'b01;
  localparam logic [1:0] ENTRY_HAS_NEXT = 2'b10;

  // One request item.
  typedef struct packed {
    logic [1:0]        operation;
    logic [DATA_W-1:0] request_bytes;
    logic [DATA_W-1:0] release_address;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [DATA_W-1:0] granted_address;
    logic [1:0]        status;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RCP_LO,
    S_RCP_HI,
    S_REM,
    S_ALLOC_CHECK,
    S_SCAN,
    S_MARK,
    S_MUL,
    S_ADD,
    S_FREE_CHECK,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

endpackage

// ----- hdl/block_table_first_fit_allocator_core.sv -----
// First-fit heap allocator over a block table, driven by a small sequencer.
//
// The block handles one item at a time; in_stall is high from acceptance until the
// result has been handed to the output register. The byte count of an allocate, or the
// heap offset of a free, is turned into blocks by two halves of a multiplication by the
// reciprocal of BLOCK_BYTES and a remainder check. An allocate then takes a check step,
// a scan that reads one table entry after another behind the registered read port, a
// write per block marked, and the address arithmetic and hand-off. When no run fits the
// scan goes to the end of the effective table, and a request larger than the heap is
// rejected at the check step. A free reads and clears each block along the chain in
// turn. A zero size or an unknown operation goes straight to the hand-off, and a clear
// sweeps the whole table. The hand-off waits until the output register is free. After
// reset the same sweep runs over the whole table before the first item is accepted;
// configuration writes are taken throughout. The single read port of the table memory
// sets the scan speed. BLOCK_BYTES need not be a power of two.
module block_table_first_fit_allocator_core #(
  parameter int unsigned NUM_BLOCKS  = 1024,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  btff_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output btff_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  import btff_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);

  // Reciprocal of the block size, exact for every 32-bit dividend, split in two halves.
  localparam int unsigned SHIFT_L = $clog2(BLOCK_BYTES);
  localparam int unsigned LO_W    = 16;
  localparam int unsigned HI_W    = 17;
  localparam int unsigned RCP_W   = DATA_W + LO_W + HI_W;
  localparam logic [63:0] RECIP   = ((64'd1 << (DATA_W + SHIFT_L)) + 64'(BLOCK_BYTES)
                                     - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP[LO_W+HI_W-1:LO_W];

  // Configuration registers.
  logic [DATA_W-1:0] base_address;
  logic [10:0]       blocks_in_use;

  // Block table memory.
  logic [1:0]       table_mem [NUM_BLOCKS];
  logic [1:0]       rd_data;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [1:0]       mem_wdata;

  // Sequencer and datapath registers.
  state_t            state, state_next;
  logic              clr_reply, clr_reply_next;
  logic [CNT_W-1:0]  clr_idx, clr_idx_next;
  logic              out_valid_next;
  out_item_t         out_data_next;
  logic              is_alloc, is_alloc_next;
  logic [DATA_W-1:0] div_x, div_x_next;
  logic [RCP_W-1:0]  rcp_acc, rcp_acc_next;
  logic [DATA_W-1:0] div_q, div_q_next;
  logic              div_rem_nz, div_rem_nz_next;
  logic [CNT_W-1:0]  need_cnt, need_cnt_next;
  logic [CNT_W-1:0]  scan_idx, scan_idx_next;
  logic              pend, pend_next;
  logic [CNT_W-1:0]  pend_idx, pend_idx_next;
  logic [CNT_W-1:0]  run, run_next;
  logic [CNT_W-1:0]  start, start_next;
  logic [CNT_W-1:0]  mark_idx, mark_idx_next;
  logic [CNT_W-1:0]  mark_left, mark_left_next;
  logic [DATA_W-1:0] prod, prod_next;
  logic [DATA_W-1:0] res_addr, res_addr_next;
  logic [1:0]        res_status, res_status_next;

  // Shared working signals.
  logic [CNT_W-1:0]       total;
  logic [DATA_W+LO_W-1:0] rcp_lo;
  logic [DATA_W+HI_W-1:0] rcp_hi;
  logic [DATA_W-1:0]      quot;
  logic [DATA_W-1:0]      quot_back;
  logic [DATA_W-1:0]      need_full;
  logic [CNT_W-1:0]       run_inc;

  // Configuration writes are taken at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= '0;
      blocks_in_use <= BLOCKS_IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_ADDRESS:  base_address  <= cfg_data;
        CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Effective table size: blocks_in_use saturated to the table depth.
  always_comb begin
    if (32'(blocks_in_use) > 32'(NUM_BLOCKS)) begin
      total = CNT_W'(NUM_BLOCKS);
    end else begin
      total = CNT_W'(blocks_in_use);
    end
  end

  // Partial products of the dividend with the two halves of the reciprocal.
  assign rcp_lo = (DATA_W + LO_W)'(div_x) * (DATA_W + LO_W)'(RECIP_LO);
  assign rcp_hi = (DATA_W + HI_W)'(div_x) * (DATA_W + HI_W)'(RECIP_HI);

  // Quotient from the full product, and the quotient scaled back for the remainder.
  assign quot      = DATA_W'(rcp_acc >> (DATA_W + SHIFT_L));
  assign quot_back = quot * DATA_W'(BLOCK_BYTES);

  // Blocks needed: quotient rounded up when a remainder is left.
  assign need_full = div_q + DATA_W'(div_rem_nz);

  assign run_inc = run + CNT_W'(1);

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[mem_raddr];
  end

  // State register and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_reply <= 1'b0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_reply <= clr_reply_next;
      clr_idx   <= clr_idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    out_data   <= out_data_next;
    is_alloc   <= is_alloc_next;
    div_x      <= div_x_next;
    rcp_acc    <= rcp_acc_next;
    div_q      <= div_q_next;
    div_rem_nz <= div_rem_nz_next;
    need_cnt   <= need_cnt_next;
    scan_idx   <= scan_idx_next;
    pend       <= pend_next;
    pend_idx   <= pend_idx_next;
    run        <= run_next;
    start      <= start_next;
    mark_idx   <= mark_idx_next;
    mark_left  <= mark_left_next;
    prod       <= prod_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
  end

  // Sequencer: next state, datapath updates and memory control.
  always_comb begin
    state_next      = state;
    clr_reply_next  = clr_reply;
    clr_idx_next    = clr_idx;
    out_valid_next  = out_valid && out_stall;
    out_data_next   = out_data;
    is_alloc_next   = is_alloc;
    div_x_next      = div_x;
    rcp_acc_next    = rcp_acc;
    div_q_next      = div_q;
    div_rem_nz_next = div_rem_nz;
    need_cnt_next   = need_cnt;
    scan_idx_next   = scan_idx;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    run_next        = run;
    start_next      = start;
    mark_idx_next   = mark_idx;
    mark_left_next  = mark_left;
    prod_next       = prod;
    res_addr_next   = res_addr;
    res_status_next = res_status;
    in_stall        = 1'b1;
    mem_raddr       = '0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = ENTRY_FREE;

    case (state)
      // Sweep the whole table to free, after reset or on a clear request.
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx[IDX_W-1:0];
        clr_idx_next = clr_idx + CNT_W'(1);
        if (clr_idx == CNT_W'(NUM_BLOCKS - 1)) begin
          clr_idx_next    = '0;
          clr_reply_next  = 1'b0;
          res_status_next = ST_OK;
          state_next      = clr_reply ? S_DONE : S_IDLE;
        end
      end

      // Accept an item and start its work.
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          res_addr_next   = '0;
          res_status_next = ST_INVALID;
          case (in_data.operation)
            OP_ALLOCATE: begin
              is_alloc_next = 1'b1;
              div_x_next    = in_data.request_bytes;
              if (in_data.request_bytes == '0) begin
                state_next = S_DONE;
              end else begin
                state_next = S_RCP_LO;
              end
            end
            OP_FREE: begin
              is_alloc_next = 1'b0;
              div_x_next    = in_data.release_address - base_address;
              if (in_data.release_address < base_address) begin
                state_next = S_DONE;
              end else begin
                state_next = S_RCP_LO;
              end
            end
            OP_CLEAR: begin
              clr_reply_next = 1'b1;
              clr_idx_next   = '0;
              state_next     = S_CLEAR;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // Low half of the reciprocal product.
      S_RCP_LO: begin
        rcp_acc_next = RCP_W'(rcp_lo);
        state_next   = S_RCP_HI;
      end

      // High half of the reciprocal product, added in at its weight.
      S_RCP_HI: begin
        rcp_acc_next = rcp_acc + {rcp_hi, {LO_W{1'b0}}};
        state_next   = S_REM;
      end

      // Keep the quotient and note whether anything is left over.
      S_REM: begin
        div_q_next      = quot;
        div_rem_nz_next = quot_back != div_x;
        state_next      = is_alloc ? S_ALLOC_CHECK : S_FREE_CHECK;
      end

      // Reject requests larger than the effective table size, else start the scan.
      S_ALLOC_CHECK: begin
        need_cnt_next = need_full[CNT_W-1:0];
        scan_idx_next = '0;
        pend_next     = 1'b0;
        run_next      = '0;
        if (need_full > 32'(total)) begin
          res_status_next = ST_NOMEM;
          state_next      = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end

      // Pipelined scan: issue one read a cycle and check the entry read last cycle.
      S_SCAN: begin
        if (scan_idx < total) begin
          mem_raddr     = scan_idx[IDX_W-1:0];
          scan_idx_next = scan_idx + CNT_W'(1);
          pend_next     = 1'b1;
          pend_idx_next = scan_idx;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          if (rd_data != ENTRY_FREE) begin
            run_next = '0;
          end else begin
            run_next = run_inc;
            if (run == '0) begin
              start_next = pend_idx;
            end
            if (run_inc == need_cnt) begin
              mark_idx_next  = (run == '0) ? pend_idx : start;
              mark_left_next = need_cnt;
              state_next     = S_MARK;
            end
          end
        end else if (scan_idx >= total) begin
          res_status_next = ST_NOMEM;
          state_next      = S_DONE;
        end
      end

      // Mark the run taken, chaining every entry but the last.
      S_MARK: begin
        mem_we         = 1'b1;
        mem_waddr      = mark_idx[IDX_W-1:0];
        mem_wdata      = (mark_left == CNT_W'(1)) ? ENTRY_TAKEN
                                                  : (ENTRY_TAKEN | ENTRY_HAS_NEXT);
        mark_idx_next  = mark_idx + CNT_W'(1);
        mark_left_next = mark_left - CNT_W'(1);
        if (mark_left == CNT_W'(1)) begin
          state_next = S_MUL;
        end
      end

      // Byte offset of the run start.
      S_MUL: begin
        prod_next  = DATA_W'(start) * DATA_W'(BLOCK_BYTES);
        state_next = S_ADD;
      end

      // Granted address, wrapping at 32 bits.
      S_ADD: begin
        res_addr_next   = base_address + prod;
        res_status_next = ST_OK;
        state_next      = S_DONE;
      end

      // Reject a free beyond the heap, else start the chain walk.
      S_FREE_CHECK: begin
        mark_idx_next = div_q[CNT_W-1:0];
        if (div_q >= 32'(total)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FREE_RD;
        end
      end

      // Read the current chain entry.
      S_FREE_RD: begin
        mem_raddr  = mark_idx[IDX_W-1:0];
        state_next = S_FREE_WR;
      end

      // Clear it and follow the chain while it continues inside the heap.
      S_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mark_idx[IDX_W-1:0];
        if (((rd_data & ENTRY_HAS_NEXT) != ENTRY_FREE) &&
            (mark_idx + CNT_W'(1) < total)) begin
          mark_idx_next = mark_idx + CNT_W'(1);
          state_next    = S_FREE_RD;
        end else begin
          res_status_next = ST_OK;
          state_next      = S_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next                = 1'b1;
          out_data_next.granted_address = res_addr;
          out_data_next.status          = res_status;
          state_next                    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
